@@ hdl/fhl_pkg.sv @@
// fhl_pkg: widths, register indexes, palette codes and arithmetic constants
// for the fire heat led effect. No dependencies; used by the interfaces and the top level.
`timescale 1ns / 1ps

package fhl_pkg;

	// field widths
	localparam int COOL_W    = 10;
	localparam int SPOS_W    = 3;
	localparam int SHEAT_W   = 8;
	localparam int HEAT_W    = 8;
	localparam int PIX_W     = 11;
	localparam int COLOR_W   = 8;
	localparam int COUNT_W   = 9;
	localparam int START_W   = 10;
	localparam int MODE_W    = 4;

	// configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 10;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_LED_COUNT  = 2'd0,
		REG_START_LED  = 2'd1,
		REG_COLOR_MODE = 2'd2,
		REG_UNUSED     = 2'd3
	} cfg_reg_t;

	// palette codes; codes above lime fall back to red
	localparam logic [MODE_W-1:0] MODE_RED     = 4'd0;
	localparam logic [MODE_W-1:0] MODE_GREEN   = 4'd1;
	localparam logic [MODE_W-1:0] MODE_BLUE    = 4'd2;
	localparam logic [MODE_W-1:0] MODE_ORANGE  = 4'd3;
	localparam logic [MODE_W-1:0] MODE_PURPLE  = 4'd4;
	localparam logic [MODE_W-1:0] MODE_YELLOW  = 4'd5;
	localparam logic [MODE_W-1:0] MODE_CYAN    = 4'd6;
	localparam logic [MODE_W-1:0] MODE_MAGENTA = 4'd7;
	localparam logic [MODE_W-1:0] MODE_WHITE   = 4'd8;
	localparam logic [MODE_W-1:0] MODE_LIME    = 4'd9;

	// temperature bands
	typedef enum logic [1:0] {
		LVL_COOL = 2'd0,
		LVL_WARM = 2'd1,
		LVL_HOT  = 2'd2,
		LVL_NONE = 2'd3
	} heat_lvl_t;

	localparam logic [7:0] HOT_LEVEL  = 8'h80;
	localparam logic [7:0] WARM_LEVEL = 8'h40;

	// heat scaling t = (h*191 + 127) / 255
	localparam logic [15:0] SCALE_MUL = 16'd191;
	localparam logic [15:0] SCALE_RND = 16'd127;

	// x / 3 for x below 768 as (x * 683) >> 11
	localparam logic [19:0] DIV3_MUL   = 20'd683;
	localparam int          DIV3_SHIFT = 11;

	localparam int MAX_LEDS_DEF = 256;

endpackage

@@ hdl/fhl_if.sv @@
// fhl_feed_if and fhl_pixel_if: valid/ready channels for the fire heat led effect.
// Depends on fhl_pkg for field widths.
`timescale 1ns / 1ps

interface fhl_feed_if;
	import fhl_pkg::*;

	logic               valid;
	logic               ready;
	logic [COOL_W-1:0]  cool_amount;
	logic               spark_fire;
	logic [SPOS_W-1:0]  spark_pos;
	logic [SHEAT_W-1:0] spark_heat;

	modport source (output valid, cool_amount, spark_fire, spark_pos, spark_heat,
		input ready);
	modport sink (input valid, cool_amount, spark_fire, spark_pos, spark_heat,
		output ready);
endinterface

interface fhl_pixel_if;
	import fhl_pkg::*;

	logic               valid;
	logic               ready;
	logic [PIX_W-1:0]   pixel_index;
	logic [COLOR_W-1:0] red;
	logic [COLOR_W-1:0] green;
	logic [COLOR_W-1:0] blue;
	logic               frame_end;

	modport source (output valid, pixel_index, red, green, blue, frame_end,
		input ready);
	modport sink (input valid, pixel_index, red, green, blue, frame_end,
		output ready);
endinterface

@@ hdl/fire_heat_led_effect.sv @@
// fire_heat_led_effect: fire heat simulation, one led per word, heat kept in a
// single-port-per-side synchronous memory. Depends on fhl_pkg and fhl_if.sv.
//
//   channel  dir  contents
//   feed     in   cool_amount, spark_fire, spark_pos, spark_heat
//   pixel    out  pixel_index, red, green, blue, frame_end
//   cfg      in   cfg_wr_en, cfg_index, cfg_data (led_count, start_led, color_mode)
//
// One word per cycle sustained while pixel.ready is high; from feed to pixel a word passes
// the heat memory read, then the update and write-back, then the output register.
// A back-to-back read of the entry being written is served by forwarding.
// After reset the heat memory is cleared, one entry per cycle, for all MAX_LEDS entries;
// feed.ready stays low during that pass. A stalled pixel holds the update stage,
// and feed.ready drops once that stage is full.
`timescale 1ns / 1ps

module fire_heat_led_effect #(
	parameter int MAX_LEDS = fhl_pkg::MAX_LEDS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_wr_en,
	input  logic [fhl_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [fhl_pkg::CFG_DATA_W-1:0]    cfg_data,
	fhl_feed_if.sink                          feed,
	fhl_pixel_if.source                       pixel
);
	import fhl_pkg::*;

	localparam int PW   = $clog2(MAX_LEDS);
	localparam int CNTW = (PW + 1 > COUNT_W) ? PW + 1 : COUNT_W;

	// palette lookup from scaled temperature
	function automatic logic [3*COLOR_W-1:0] palette(input logic [7:0] t,
		input logic [MODE_W-1:0] mode);
		logic [7:0] ramp;
		logic [7:0] half;
		heat_lvl_t  lvl;
		logic [7:0] r, g, b;
		ramp = {t[5:0], 2'b00};
		half = ramp >> 1;
		lvl  = (t > HOT_LEVEL) ? LVL_HOT : ((t > WARM_LEVEL) ? LVL_WARM : LVL_COOL);
		r = 8'd0;
		g = 8'd0;
		b = 8'd0;
		case (mode)
			MODE_GREEN: begin
				if (lvl == LVL_HOT) begin r = ramp; g = 8'd255; b = ramp; end
				else if (lvl == LVL_WARM) begin r = 8'd0; g = 8'd255; b = half; end
				else begin r = 8'd0; g = ramp; b = 8'd0; end
			end
			MODE_BLUE: begin
				if (lvl == LVL_HOT) begin r = ramp; g = ramp; b = 8'd255; end
				else if (lvl == LVL_WARM) begin r = 8'd0; g = ramp; b = 8'd255; end
				else begin r = 8'd0; g = 8'd0; b = ramp; end
			end
			MODE_ORANGE: begin
				if (lvl == LVL_HOT) begin r = 8'd255; g = 8'd255; b = ramp; end
				else if (lvl == LVL_WARM) begin r = 8'd255; g = ramp; b = 8'd0; end
				else begin r = ramp; g = half; b = 8'd0; end
			end
			MODE_PURPLE: begin
				if (lvl == LVL_HOT) begin r = 8'd255; g = ramp; b = 8'd255; end
				else if (lvl == LVL_WARM) begin r = 8'd255; g = 8'd0; b = ramp; end
				else begin r = ramp; g = 8'd0; b = ramp; end
			end
			MODE_YELLOW: begin
				if (lvl == LVL_HOT) begin r = 8'd255; g = 8'd255; b = ramp; end
				else if (lvl == LVL_WARM) begin r = 8'd255; g = 8'd255; b = 8'd0; end
				else begin r = ramp; g = ramp; b = 8'd0; end
			end
			MODE_CYAN: begin
				if (lvl == LVL_HOT) begin r = ramp; g = 8'd255; b = 8'd255; end
				else if (lvl == LVL_WARM) begin r = 8'd0; g = 8'd255; b = 8'd255; end
				else begin r = 8'd0; g = ramp; b = ramp; end
			end
			MODE_MAGENTA: begin
				if (lvl == LVL_HOT) begin r = 8'd255; g = ramp; b = 8'd255; end
				else if (lvl == LVL_WARM) begin r = 8'd255; g = 8'd0; b = 8'd255; end
				else begin r = ramp; g = 8'd0; b = ramp; end
			end
			MODE_WHITE: begin
				if (lvl == LVL_HOT) begin r = 8'd255; g = 8'd255; b = 8'd255; end
				else if (lvl == LVL_WARM) begin r = ramp; g = ramp; b = 8'd255; end
				else begin r = ramp; g = ramp; b = ramp; end
			end
			MODE_LIME: begin
				if (lvl == LVL_HOT) begin r = 8'd255; g = 8'd255; b = ramp; end
				else if (lvl == LVL_WARM) begin r = ramp; g = 8'd255; b = 8'd0; end
				else begin r = half; g = ramp; b = 8'd0; end
			end
			default: begin
				if (lvl == LVL_HOT) begin r = 8'd255; g = 8'd255; b = ramp; end
				else if (lvl == LVL_WARM) begin r = 8'd255; g = ramp; b = 8'd0; end
				else begin r = ramp; g = 8'd0; b = 8'd0; end
			end
		endcase
		return {r, g, b};
	endfunction

	// configuration registers
	logic [COUNT_W-1:0] led_count_q;
	logic [START_W-1:0] start_led_q;
	logic [MODE_W-1:0]  color_mode_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			led_count_q  <= COUNT_W'(1);
			start_led_q  <= '0;
			color_mode_q <= MODE_RED;
		end else if (cfg_wr_en) begin
			case (cfg_reg_t'(cfg_index))
				REG_LED_COUNT:  led_count_q  <= cfg_data[COUNT_W-1:0];
				REG_START_LED:  start_led_q  <= cfg_data[START_W-1:0];
				REG_COLOR_MODE: color_mode_q <= cfg_data[MODE_W-1:0];
				default: ;
			endcase
		end
	end

	// effective frame length, clamped to 1..MAX_LEDS
	logic [PW:0] eff_count;

	always_comb begin
		if (led_count_q == '0)
			eff_count = (PW+1)'(1);
		else if (CNTW'(led_count_q) > CNTW'(MAX_LEDS))
			eff_count = (PW+1)'(MAX_LEDS);
		else
			eff_count = (PW+1)'(led_count_q);
	end

	// clearing pass after reset
	logic          clr_busy_q;
	logic [PW-1:0] clr_addr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_busy_q) begin
			clr_addr_q <= clr_addr_q + 1'b1;
			if (clr_addr_q == PW'(MAX_LEDS - 1))
				clr_busy_q <= 1'b0;
		end
	end

	// handshake and stage control
	logic s1_valid_q;
	logic s2_valid_q;
	logic s1_adv;
	logic in_acc;

	assign s1_adv     = s1_valid_q && (!s2_valid_q || pixel.ready);
	assign feed.ready = !clr_busy_q && (!s1_valid_q || s1_adv);
	assign in_acc     = feed.valid && feed.ready;

	// frame position and spark latch
	logic [PW-1:0]      led_pos_q;
	logic               spark_vld_q;
	logic [SPOS_W-1:0]  spark_pos_q;
	logic [SHEAT_W-1:0] spark_heat_q;
	logic [PW:0]        pos_inc;
	logic               in_last;

	assign pos_inc = {1'b0, led_pos_q} + 1'b1;
	assign in_last = (pos_inc >= eff_count);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			led_pos_q   <= '0;
			spark_vld_q <= 1'b0;
		end else if (in_acc) begin
			led_pos_q <= in_last ? '0 : pos_inc[PW-1:0];
			if (led_pos_q == '0)
				spark_vld_q <= feed.spark_fire;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc && led_pos_q == '0) begin
			spark_pos_q  <= feed.spark_pos;
			spark_heat_q <= feed.spark_heat;
		end
	end

	// update stage signals
	logic [PW-1:0]     pos_s1;
	logic [COOL_W-1:0] cool_s1;
	logic              last_s1;
	logic              fwd_s1;
	logic [HEAT_W-1:0] fwd_heat_s1;
	logic [HEAT_W-1:0] heat_rd_q;
	logic [HEAT_W-1:0] new_heat;

	// heat memory: write from clearing pass or update stage, read on accept
	logic [HEAT_W-1:0] heat_mem [MAX_LEDS];
	logic              mem_we;
	logic [PW-1:0]     mem_wa;
	logic [HEAT_W-1:0] mem_wd;

	assign mem_we = clr_busy_q || s1_adv;
	assign mem_wa = clr_busy_q ? clr_addr_q : pos_s1;
	assign mem_wd = clr_busy_q ? '0 : new_heat;

	always_ff @(posedge clk) begin
		if (mem_we)
			heat_mem[mem_wa] <= mem_wd;
		if (in_acc)
			heat_rd_q <= heat_mem[led_pos_q];
	end

	// stage 1 registers; forward when the read hits the entry written this edge
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			s1_valid_q <= 1'b0;
		else if (in_acc)
			s1_valid_q <= 1'b1;
		else if (s1_adv)
			s1_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			pos_s1      <= led_pos_q;
			cool_s1     <= feed.cool_amount;
			last_s1     <= in_last;
			fwd_s1      <= s1_adv && (pos_s1 == led_pos_q);
			fwd_heat_s1 <= new_heat;
		end
	end

	// cool, diffuse and spark
	logic [HEAT_W-1:0]   cooled_prev_q;
	logic [HEAT_W-1:0]   cooled_prev2_q;
	logic [HEAT_W-1:0]   stored;
	logic [HEAT_W-1:0]   cooled;
	logic [HEAT_W+1:0]   diff_sum;
	logic [19:0]         diff_prod;
	logic [HEAT_W-1:0]   base_heat;
	logic [HEAT_W:0]     spark_sum;
	logic                spark_hit;

	always_comb begin
		stored    = fwd_s1 ? fwd_heat_s1 : heat_rd_q;
		cooled    = ({2'b00, stored} > cool_s1) ? HEAT_W'({2'b00, stored} - cool_s1) : '0;
		diff_sum  = {2'b00, cooled_prev_q} + {1'b0, cooled_prev2_q, 1'b0};
		diff_prod = 20'(diff_sum) * DIV3_MUL;
		base_heat = (pos_s1 >= PW'(2)) ? HEAT_W'(diff_prod >> DIV3_SHIFT) : cooled;
		spark_hit = spark_vld_q && (pos_s1 == PW'(spark_pos_q));
		spark_sum = {1'b0, base_heat} + {1'b0, spark_heat_q};
		if (spark_hit)
			new_heat = spark_sum[HEAT_W] ? '1 : spark_sum[HEAT_W-1:0];
		else
			new_heat = base_heat;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cooled_prev_q  <= '0;
			cooled_prev2_q <= '0;
		end else if (s1_adv) begin
			cooled_prev_q  <= cooled;
			cooled_prev2_q <= cooled_prev_q;
		end
	end

	// output register
	logic [HEAT_W-1:0] heat_s2;
	logic [PIX_W-1:0]  pix_s2;
	logic              last_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			s2_valid_q <= 1'b0;
		else if (s1_adv)
			s2_valid_q <= 1'b1;
		else if (pixel.ready)
			s2_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			heat_s2 <= new_heat;
			pix_s2  <= PIX_W'(start_led_q) + PIX_W'(pos_s1);
			last_s2 <= last_s1;
		end
	end

	// scale heat to 0..191 and apply palette
	logic [15:0]          scaled;
	logic [16:0]          div_sum;
	logic [7:0]           temp;
	logic [3*COLOR_W-1:0] rgb;

	always_comb begin
		scaled  = 16'(heat_s2) * SCALE_MUL + SCALE_RND;
		div_sum = 17'(scaled) + 17'(scaled >> 8) + 17'd1;
		temp    = 8'(div_sum >> 8);
		rgb     = palette(temp, color_mode_q);
	end

	assign pixel.valid       = s2_valid_q;
	assign pixel.pixel_index = pix_s2;
	assign pixel.red         = rgb[3*COLOR_W-1:2*COLOR_W];
	assign pixel.green       = rgb[2*COLOR_W-1:COLOR_W];
	assign pixel.blue        = rgb[COLOR_W-1:0];
	assign pixel.frame_end   = last_s2;

endmodule
